>>> rtl/core/wwlf_pkg.sv
// Shared constants, types and command/status structs for the line folder.
// Used by the channel interfaces, the controller and the datapath.
package wwlf_pkg;

   localparam int LINE_LEN  = 32;
   localparam int TAB_WIDTH = 4;

   localparam int CHAR_W = 8;
   localparam int IDX_W  = $clog2(LINE_LEN);
   localparam int LEN_W  = $clog2(LINE_LEN + 1);
   localparam int SRC_W  = $clog2(LINE_LEN + 2);
   localparam int PH_W   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

   typedef logic [CHAR_W-1:0] char_type;

   localparam char_type CH_TAB = char_type'(9);
   localparam char_type CH_NL  = char_type'(10);
   localparam char_type CH_SP  = char_type'(32);

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_TAB,
      CLS_NL
   } char_cls_type;

   typedef enum logic [1:0] {
      WR_REQ,
      WR_SPACE,
      WR_COPY
   } wr_sel_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_IDX,
      RD_NL,
      RD_SRC
   } rd_sel_type;

   typedef enum logic [1:0] {
      LEN_POS,
      LEN_BRK,
      LEN_FULL
   } len_sel_type;

   typedef struct packed {
      logic        wr;
      wr_sel_type  wr_sel;
      rd_sel_type  rd_sel;
      logic        set_len;
      len_sel_type len_sel;
      logic        clear;
   } cmd_type;

   typedef struct packed {
      char_cls_type cls;
      logic         next_full;
      logic         next_stop;
      logic         idx_done;
      logic         src_done;
      logic         last_sent;
   } status_type;

endpackage

>>> rtl/core/wwlf_req_if.sv
// Input channel of the line folder: one character per item.
// Depends on wwlf_pkg for the character type.
interface wwlf_req_if;
   import wwlf_pkg::*;

   logic     valid;
   logic     ready;
   char_type in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

>>> rtl/core/wwlf_rsp_if.sv
// Result channel of the line folder: one emitted character per item.
// Depends on wwlf_pkg for the character type.
interface wwlf_rsp_if;
   import wwlf_pkg::*;

   logic     valid;
   logic     ready;
   char_type out_char;
   logic     last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

>>> rtl/core/wwlf_ctrl.sv
// Sequencing state machine of the line folder.
// Depends on wwlf_pkg; drives the datapath through cmd_type and reads status_type.
module wwlf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wwlf_pkg::status_type status,
   output wwlf_pkg::cmd_type    cmd
);
   import wwlf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAB,
      ST_BRK,
      ST_RD,
      ST_SHOW,
      ST_CP_RD,
      ST_CP_WR
   } state_type;

   state_type state_ff, state_in;
   logic      copy_ff, copy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         copy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         copy_ff  <= copy_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);

   always_comb begin
      state_in    = state_ff;
      copy_in     = copy_ff;
      cmd         = '0;
      cmd.wr_sel  = WR_REQ;
      cmd.rd_sel  = RD_NONE;
      cmd.len_sel = LEN_POS;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (status.cls)
                  CLS_NL: begin
                     cmd.set_len = 1'b1;
                     cmd.len_sel = LEN_POS;
                     copy_in     = 1'b0;
                     state_in    = ST_RD;
                  end
                  CLS_TAB: begin
                     cmd.wr     = 1'b1;
                     cmd.wr_sel = WR_SPACE;
                     if (status.next_full) begin
                        cmd.set_len = 1'b1;
                        cmd.len_sel = LEN_FULL;
                        copy_in     = 1'b0;
                        state_in    = ST_RD;
                     end else if (!status.next_stop) begin
                        state_in = ST_TAB;
                     end
                  end
                  default: begin
                     cmd.wr     = 1'b1;
                     cmd.wr_sel = WR_REQ;
                     if (status.next_full) begin
                        state_in = ST_BRK;
                     end
                  end
               endcase
            end
         end
         ST_TAB: begin
            cmd.wr     = 1'b1;
            cmd.wr_sel = WR_SPACE;
            if (status.next_full) begin
               cmd.set_len = 1'b1;
               cmd.len_sel = LEN_FULL;
               copy_in     = 1'b0;
               state_in    = ST_RD;
            end else if (status.next_stop) begin
               state_in = ST_IDLE;
            end
         end
         ST_BRK: begin
            cmd.set_len = 1'b1;
            cmd.len_sel = LEN_BRK;
            copy_in     = 1'b1;
            state_in    = ST_RD;
         end
         ST_RD: begin
            cmd.rd_sel = status.idx_done ? RD_NL : RD_IDX;
            state_in   = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               if (status.last_sent) begin
                  cmd.clear = 1'b1;
                  state_in  = copy_ff ? ST_CP_RD : ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_CP_RD: begin
            if (status.src_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_sel = RD_SRC;
               state_in   = ST_CP_WR;
            end
         end
         ST_CP_WR: begin
            cmd.wr     = 1'b1;
            cmd.wr_sel = WR_COPY;
            state_in   = ST_CP_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/wwlf_datapath.sv
// Line store, fill pointer, break tracking and output register of the line folder.
// Depends on wwlf_pkg; commanded by wwlf_ctrl.
module wwlf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  wwlf_pkg::char_type   req_char,
   input  wwlf_pkg::cmd_type    cmd,
   output wwlf_pkg::status_type status,
   output wwlf_pkg::char_type   rsp_char,
   output logic                 rsp_last
);
   import wwlf_pkg::*;

   char_type line_mem [LINE_LEN];

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [PH_W-1:0]  phase_ff, phase_in;
   logic [LEN_W-1:0] last_sp_ff, last_sp_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [SRC_W-1:0] src_ff, src_in;
   char_type         rd_data_ff;
   logic             last_ff;
   char_type         wr_data;

   always_comb begin
      case (cmd.wr_sel)
         WR_SPACE: wr_data = CH_SP;
         WR_COPY:  wr_data = rd_data_ff;
         default:  wr_data = req_char;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         line_mem[pos_ff[IDX_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.rd_sel)
         RD_IDX: begin
            rd_data_ff <= line_mem[idx_ff[IDX_W-1:0]];
            last_ff    <= 1'b0;
         end
         RD_SRC: begin
            rd_data_ff <= line_mem[src_ff[IDX_W-1:0]];
         end
         RD_NL: begin
            rd_data_ff <= CH_NL;
            last_ff    <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      last_sp_in = last_sp_ff;
      if (cmd.clear) begin
         pos_in     = '0;
         phase_in   = '0;
         last_sp_in = '0;
      end else if (cmd.wr) begin
         pos_in   = pos_ff + LEN_W'(1);
         phase_in = (phase_ff == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_ff + PH_W'(1);
         if (wr_data == CH_SP && pos_ff != '0) begin
            last_sp_in = pos_ff;
         end
      end
   end

   always_comb begin
      len_in = len_ff;
      idx_in = idx_ff;
      src_in = src_ff;
      if (cmd.set_len) begin
         idx_in = '0;
         case (cmd.len_sel)
            LEN_POS:  len_in = pos_ff;
            LEN_BRK:  len_in = (last_sp_ff != '0) ? last_sp_ff : LEN_W'(LINE_LEN);
            default:  len_in = LEN_W'(LINE_LEN);
         endcase
      end else if (cmd.rd_sel == RD_IDX) begin
         idx_in = idx_ff + LEN_W'(1);
      end
      if (cmd.clear) begin
         src_in = SRC_W'(len_ff) + SRC_W'(1);
      end else if (cmd.rd_sel == RD_SRC) begin
         src_in = src_ff + SRC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_ff   <= '0;
         last_sp_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         last_sp_ff <= last_sp_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      idx_ff <= idx_in;
      src_ff <= src_in;
   end

   always_comb begin
      if (req_char == CH_NL) begin
         status.cls = CLS_NL;
      end else if (req_char == CH_TAB) begin
         status.cls = CLS_TAB;
      end else begin
         status.cls = CLS_OTHER;
      end
      status.next_full = (pos_ff == LEN_W'(LINE_LEN - 1));
      status.next_stop = (phase_ff == PH_W'(TAB_WIDTH - 1));
      status.idx_done  = (idx_ff == len_ff);
      status.src_done  = (src_ff >= SRC_W'(LINE_LEN));
      status.last_sent = last_ff;
   end

   assign rsp_char = rd_data_ff;
   assign rsp_last = last_ff;

endmodule

>>> rtl/core/word_wrap_line_folder.sv
// Top level of the line folder: joins the controller and the datapath to the channels.
// Depends on wwlf_pkg, wwlf_req_if, wwlf_rsp_if, wwlf_ctrl and wwlf_datapath.
//
// Characters arrive one per item and are folded into lines of at most LINE_LEN
// characters. An ordinary character that does not fill the line is taken straight
// from idle, so such characters stream at one per cycle while no line is emitted or
// moved. A tab writes spaces up to the next tab stop and takes no input meanwhile.
// All work runs through one line store: every emitted character is loaded into the
// output register by a store read (or as the newline), then held until the result
// channel takes it; a fold then moves the text after the break to the front, reading
// then writing each moved character. No new input is taken while a line is emitted or moved.
module word_wrap_line_folder (
   input logic      clock,
   input logic      reset,
   wwlf_req_if.sink   req_if,
   wwlf_rsp_if.source rsp_if
);
   import wwlf_pkg::*;

   cmd_type    cmd;
   status_type status;

   wwlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wwlf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_char (req_if.in_char),
      .cmd      (cmd),
      .status   (status),
      .rsp_char (rsp_if.out_char),
      .rsp_last (rsp_if.last_of_run)
   );

endmodule
